/* rtl/scpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package scpd_pkg;

	localparam int BLOCK_LEN_DEFAULT = 10;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 16;
	localparam int IDX_W    = 2;
	localparam int TIME_W   = 32;
	localparam int FIELD_W  = 20;
	localparam int COUNT_W  = 16;

	localparam int IN_W  = 32;
	localparam int OUT_W = 192;

	localparam logic [CFG_W-1:0] AMP_THRESHOLD_RST      = 16'd10;
	localparam logic [CFG_W-1:0] MIN_SPACING_RST        = 16'd30;
	localparam logic [CFG_W-1:0] COINCIDENCE_WINDOW_RST = 16'd5;

	typedef enum logic [IDX_W-1:0] {
		REG_AMP_THRESHOLD      = 2'd0,
		REG_MIN_SPACING        = 2'd1,
		REG_COINCIDENCE_WINDOW = 2'd2
	} reg_idx_t;

	// declared msb first: sample_time sits in the lowest bits
	typedef struct packed {
		logic [COUNT_W-1:0] cell_total;
		logic [COUNT_W-1:0] peak_total;
		logic [TIME_W-1:0]  cell_time;
		logic               cell_found;
		logic [FIELD_W-1:0] peak_side_sum;
		logic [TIME_W-1:0]  peak_time;
		logic               peak_found;
		logic [FIELD_W-1:0] side_block_sum;
		logic [FIELD_W-1:0] forward_block_sum;
		logic [TIME_W-1:0]  sample_time;
	} result_t;

endpackage
`default_nettype wire

/* rtl/scpd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module scpd_cell #(
	parameter int SUM_W = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic [SUM_W-1:0]                prev_fwd,
	input  wire logic [SUM_W-1:0]                prev_side,
	input  wire logic [scpd_pkg::TIME_W-1:0]     prev_stamp,
	output logic      [SUM_W-1:0]                fwd,
	output logic      [SUM_W-1:0]                side,
	output logic      [scpd_pkg::TIME_W-1:0]     stamp
);

	logic [SUM_W-1:0]            fwd_q;
	logic [SUM_W-1:0]            side_q;
	logic [scpd_pkg::TIME_W-1:0] stamp_q;

	// ring entries reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q   <= '0;
			side_q  <= '0;
			stamp_q <= '0;
		end else if (en) begin
			fwd_q   <= prev_fwd;
			side_q  <= prev_side;
			stamp_q <= prev_stamp;
		end
	end

	assign fwd   = fwd_q;
	assign side  = side_q;
	assign stamp = stamp_q;

endmodule
`default_nettype wire

/* rtl/scpd_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
module scpd_eval #(
	parameter int BLOCK_LEN = scpd_pkg::BLOCK_LEN_DEFAULT,
	parameter int SUM_W     = 16 + $clog2(BLOCK_LEN)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [scpd_pkg::TIME_W-1:0]     blk_time,
	input  wire logic [SUM_W-1:0]                blk_fwd,
	input  wire logic [SUM_W-1:0]                blk_side,
	input  wire logic [SUM_W-1:0]                head_fwd,
	input  wire logic [SUM_W-1:0]                head_side,
	input  wire logic [scpd_pkg::TIME_W-1:0]     head_stamp,
	input  wire logic [scpd_pkg::CFG_W-1:0]      amp_threshold,
	input  wire logic [scpd_pkg::CFG_W-1:0]      min_spacing,
	input  wire logic [scpd_pkg::CFG_W-1:0]      coincidence_window,
	output logic                                 rotate,
	output logic                                 busy,
	output scpd_pkg::result_t                    res,
	output logic                                 res_valid,
	input  wire logic                            res_ready
);

	localparam int LG    = $clog2(BLOCK_LEN);
	localparam int TOT_W = SUM_W + LG;
	localparam int CMP_W = SUM_W + 2 * LG + 2;
	localparam int TW    = scpd_pkg::TIME_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PROD,
		ST_DECIDE,
		ST_OUT
	} state_t;

	state_t                       state_q;
	logic [LG-1:0]                b_q;
	logic [TOT_W-1:0]             tot_q;
	logic [SUM_W-1:0]             fmax_q;
	logic [TW-1:0]                ftime_q;
	logic [SUM_W-1:0]             ctr_q;
	logic [TW-1:0]                ctime_q;
	logic [TW-1:0]                blk_time_q;
	logic [SUM_W-1:0]             blk_fwd_q;
	logic [SUM_W-1:0]             blk_side_q;
	logic [CMP_W-1:0]             ctr_l_s1;
	logic [CMP_W-1:0]             lim_s1;
	logic [TW-1:0]                last_peak_q;
	logic [scpd_pkg::COUNT_W-1:0] peak_cnt_q;
	logic [scpd_pkg::COUNT_W-1:0] cell_cnt_q;
	scpd_pkg::result_t            res_q;

	logic                         is_peak;
	logic                         is_cell;
	logic [TW+1:0]                space_lim;
	logic [TW:0]                  mid_sum;
	logic [SUM_W+19:0]            blk_fwd_x;
	logic [SUM_W+19:0]            blk_side_x;
	logic [SUM_W+19:0]            ctr_x;

	always_comb begin
		space_lim  = {2'b00, last_peak_q} + (TW+2)'(min_spacing);
		is_peak    = (ctr_l_s1 > lim_s1) && ({2'b00, ctime_q} > space_lim);
		is_cell    = ({1'b0, ctime_q} < {1'b0, ftime_q} + (TW+1)'(coincidence_window)) &&
			({1'b0, ftime_q} < {1'b0, ctime_q} + (TW+1)'(coincidence_window));
		mid_sum    = {1'b0, ctime_q} + {1'b0, ftime_q};
		blk_fwd_x  = {20'd0, blk_fwd_q};
		blk_side_x = {20'd0, blk_side_q};
		ctr_x      = {20'd0, ctr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			b_q         <= '0;
			last_peak_q <= '0;
			peak_cnt_q  <= '0;
			cell_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q    <= ST_SCAN;
						b_q        <= '0;
						tot_q      <= '0;
						fmax_q     <= '0;
						ftime_q    <= '0;
						ctr_q      <= '0;
						ctime_q    <= '0;
						blk_time_q <= blk_time;
						blk_fwd_q  <= blk_fwd;
						blk_side_q <= blk_side;
					end
				end
				ST_SCAN: begin
					// head cell shows entries newest first, then oldest onward
					tot_q <= tot_q + TOT_W'(head_side);
					if (head_fwd > fmax_q) begin
						fmax_q  <= head_fwd;
						ftime_q <= head_stamp;
					end
					if (b_q == LG'(BLOCK_LEN / 2) && head_side != '0) begin
						ctr_q   <= head_side;
						ctime_q <= head_stamp;
					end
					b_q <= b_q + 1'b1;
					if (b_q == LG'(BLOCK_LEN - 1)) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					ctr_l_s1 <= CMP_W'(ctr_q) * CMP_W'(BLOCK_LEN);
					lim_s1   <= CMP_W'(tot_q) +
						CMP_W'(amp_threshold) * CMP_W'(BLOCK_LEN * BLOCK_LEN);
					state_q  <= ST_DECIDE;
				end
				ST_DECIDE: begin
					res_q.sample_time       <= blk_time_q;
					res_q.forward_block_sum <= blk_fwd_x[19:0];
					res_q.side_block_sum    <= blk_side_x[19:0];
					res_q.peak_found        <= is_peak;
					res_q.peak_time         <= is_peak ? ctime_q : '0;
					res_q.peak_side_sum     <= is_peak ? ctr_x[19:0] : '0;
					res_q.cell_found        <= is_peak && is_cell;
					res_q.cell_time         <= (is_peak && is_cell) ? mid_sum[TW:1] : '0;
					res_q.peak_total        <= (is_peak && peak_cnt_q != '1) ?
						peak_cnt_q + 1'b1 : peak_cnt_q;
					res_q.cell_total        <= (is_peak && is_cell && cell_cnt_q != '1) ?
						cell_cnt_q + 1'b1 : cell_cnt_q;
					if (is_peak) begin
						last_peak_q <= ctime_q;
						if (peak_cnt_q != '1) begin
							peak_cnt_q <= peak_cnt_q + 1'b1;
						end
						if (is_cell && cell_cnt_q != '1) begin
							cell_cnt_q <= cell_cnt_q + 1'b1;
						end
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rotate    = (state_q == ST_SCAN);
	assign busy      = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_OUT);
	assign res       = res_q;

endmodule
`default_nettype wire

/* rtl/scatter_peak_and_cell_detector_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Scatter peak and cell detector.
// s_tdata carries one forward/side sample pair per word; a result word leaves
// on m_tdata once per BLOCK_LEN accepted samples, none otherwise.
// Samples are taken one per cycle. The last sample of a block stores the block
// sums in a row of BLOCK_LEN shift cells and starts a scan: the row rotates
// past one evaluator, then the PROD and DECIDE states form the threshold,
// spacing and coincidence decision; m_tvalid is high in the OUT state until
// the result word is taken.
// While a result is being formed or waits on m_tready, samples keep flowing
// except the last one of the next block, which is held until the result word
// is taken. Back-to-back blocks therefore wait on the scan, and a stall on
// m_tready while a result is waiting delays them further.
// cfg_we writes cfg_data into the register selected by cfg_index (0 amp
// threshold, 1 min spacing, 2 coincidence window); other indexes are ignored.
// arst_n clears accumulators, sample time, ring cells, last peak time and both
// counters, and loads the register defaults 10, 30 and 5.
module scatter_peak_and_cell_detector_core #(
	parameter int BLOCK_LEN = scpd_pkg::BLOCK_LEN_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [scpd_pkg::IN_W-1:0]     s_tdata,  // forward_sample, side_sample
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// sample_time, forward_block_sum, side_block_sum, peak_found, peak_time,
	// peak_side_sum, cell_found, cell_time, peak_total, cell_total
	output logic      [scpd_pkg::OUT_W-1:0]    m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [scpd_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [scpd_pkg::CFG_W-1:0]    cfg_data
);

	localparam int LG    = $clog2(BLOCK_LEN);
	localparam int SUM_W = 16 + LG;
	localparam int TW    = scpd_pkg::TIME_W;

	logic [scpd_pkg::CFG_W-1:0] amp_threshold_q;
	logic [scpd_pkg::CFG_W-1:0] min_spacing_q;
	logic [scpd_pkg::CFG_W-1:0] coincidence_window_q;

	logic [SUM_W-1:0] acc_fwd_q;
	logic [SUM_W-1:0] acc_side_q;
	logic [LG-1:0]    cnt_q;
	logic [TW-1:0]    time_q;

	logic             take;
	logic             last;
	logic             insert;
	logic             rotate;
	logic             busy;
	logic [SUM_W-1:0] new_fwd;
	logic [SUM_W-1:0] new_side;
	logic [TW-1:0]    new_time;

	logic [SUM_W-1:0] cell_fwd  [BLOCK_LEN];
	logic [SUM_W-1:0] cell_side [BLOCK_LEN];
	logic [TW-1:0]    cell_stamp[BLOCK_LEN];

	scpd_pkg::result_t res;

	assign last     = (cnt_q == LG'(BLOCK_LEN - 1));
	assign s_tready = !last || !busy;
	assign take     = s_tvalid && s_tready;
	assign insert   = take && last;
	assign new_fwd  = acc_fwd_q + SUM_W'(s_tdata[15:0]);
	assign new_side = acc_side_q + SUM_W'(s_tdata[31:16]);
	assign new_time = time_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_threshold_q      <= scpd_pkg::AMP_THRESHOLD_RST;
			min_spacing_q        <= scpd_pkg::MIN_SPACING_RST;
			coincidence_window_q <= scpd_pkg::COINCIDENCE_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scpd_pkg::REG_AMP_THRESHOLD:      amp_threshold_q      <= cfg_data;
				scpd_pkg::REG_MIN_SPACING:        min_spacing_q        <= cfg_data;
				scpd_pkg::REG_COINCIDENCE_WINDOW: coincidence_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_fwd_q  <= '0;
			acc_side_q <= '0;
			cnt_q      <= '0;
			time_q     <= '0;
		end else if (take) begin
			time_q <= new_time;
			if (last) begin
				acc_fwd_q  <= '0;
				acc_side_q <= '0;
				cnt_q      <= '0;
			end else begin
				acc_fwd_q  <= new_fwd;
				acc_side_q <= new_side;
				cnt_q      <= cnt_q + 1'b1;
			end
		end
	end

	// cell 0 is the newest block; the row shifts on insert and rotates on scan
	for (genvar k = 0; k < BLOCK_LEN; k++) begin : g_cell
		if (k == 0) begin : g_head
			scpd_cell #(.SUM_W(SUM_W)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (insert || rotate),
				.prev_fwd   (insert ? new_fwd  : cell_fwd[BLOCK_LEN-1]),
				.prev_side  (insert ? new_side : cell_side[BLOCK_LEN-1]),
				.prev_stamp (insert ? new_time : cell_stamp[BLOCK_LEN-1]),
				.fwd        (cell_fwd[k]),
				.side       (cell_side[k]),
				.stamp      (cell_stamp[k])
			);
		end else begin : g_body
			scpd_cell #(.SUM_W(SUM_W)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (insert || rotate),
				.prev_fwd   (cell_fwd[k-1]),
				.prev_side  (cell_side[k-1]),
				.prev_stamp (cell_stamp[k-1]),
				.fwd        (cell_fwd[k]),
				.side       (cell_side[k]),
				.stamp      (cell_stamp[k])
			);
		end
	end

	scpd_eval #(
		.BLOCK_LEN (BLOCK_LEN),
		.SUM_W     (SUM_W)
	) u_eval (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (insert),
		.blk_time           (new_time),
		.blk_fwd            (new_fwd),
		.blk_side           (new_side),
		.head_fwd           (cell_fwd[0]),
		.head_side          (cell_side[0]),
		.head_stamp         (cell_stamp[0]),
		.amp_threshold      (amp_threshold_q),
		.min_spacing        (min_spacing_q),
		.coincidence_window (coincidence_window_q),
		.rotate             (rotate),
		.busy               (busy),
		.res                (res),
		.res_valid          (m_tvalid),
		.res_ready          (m_tready)
	);

	assign m_tdata = scpd_pkg::OUT_W'(res);

endmodule
`default_nettype wire

/* rtl/scpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module scpd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [scpd_pkg::OUT_W-1:0]  m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid)
		else $error("result word repeated");

	a_cell_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[125] |-> m_tdata[72])
		else $error("cell without peak");

	a_no_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[72] |-> m_tdata[104:73] == 32'd0 && m_tdata[124:105] == 20'd0)
		else $error("peak fields set without peak");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[189:174] <= m_tdata[173:158])
		else $error("cell total above peak total");

endmodule

bind scatter_peak_and_cell_detector_core scpd_checker u_scpd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
